FILE: rtl/core/dlq_pkg.sv
// Shared types, codes and sizes of the doubly linked queue manager.
`default_nettype none

package dlq_pkg;

   // Default pool size and the fixed width of a node index on the ports.
   localparam int DLQ_NODES  = 64;
   localparam int NODE_W     = 6;
   localparam int NODE_SPACE = 1 << NODE_W;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [1:0]        cmd_type;
   typedef logic [1:0]        status_type;
   typedef logic [1:0]        kind_type;

   // Commands on the request channel.
   localparam cmd_type CMD_PUSH   = 2'd0;
   localparam cmd_type CMD_POP    = 2'd1;
   localparam cmd_type CMD_REMOVE = 2'd2;
   localparam cmd_type CMD_TEST   = 2'd3;

   // Result status codes.
   localparam status_type ST_OK           = 2'd0;
   localparam status_type ST_POP_EMPTY    = 2'd1;
   localparam status_type ST_PUSH_REFUSED = 2'd2;
   localparam status_type ST_REMOVE_MISS  = 2'd3;

   // Work kinds handed from the front to the back.
   localparam kind_type KIND_REPORT = 2'd0;
   localparam kind_type KIND_PUSH   = 2'd1;
   localparam kind_type KIND_POP    = 2'd2;
   localparam kind_type KIND_REMOVE = 2'd3;

   typedef struct packed {
      cmd_type  cmd;
      node_type node;
   } dlq_req_type;

   typedef struct packed {
      node_type   node_out;
      logic       node_out_valid;
      logic       found;
      logic       empty_res;
      status_type status;
   } dlq_rsp_type;

   // One classified word waiting for the back.
   typedef struct packed {
      kind_type   kind;
      node_type   node;
      logic       found;
      status_type status;
   } dlq_entry_type;

   // What the back tells the front each cycle.
   typedef struct packed {
      logic     done;
      logic     nonempty;
      node_type head;
   } dlq_back_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/dlq_fifo.sv
// Two-entry queue of classified words between the front and the back.
`default_nettype none

module dlq_fifo
   import dlq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  dlq_entry_type      push_data,
   input  wire logic          pop,
   output logic               not_empty,
   output dlq_entry_type      head_data
);

   dlq_entry_type entry_ff [2];
   logic          wptr_ff, wptr_in;
   logic          rptr_ff, rptr_in;
   logic [1:0]    count_ff, count_in;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   assign not_empty = (count_ff != 2'd0);
   assign head_data = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/dlq_front.sv
// Front: accepts commands, checks membership and guards, queues the work.
`default_nettype none

module dlq_front
   import dlq_pkg::*;
#(
   parameter int NODES = DLQ_NODES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  dlq_req_type        req_data,
   input  dlq_back_stat_type  back_stat,
   output logic               fifo_push,
   output dlq_entry_type      fifo_entry
);

   logic [NODE_SPACE-1:0] member_ff, member_in;
   logic                  inflight_ff, inflight_in;
   logic                  accept;
   logic                  in_pool;
   logic                  is_mem;

   assign accept = start && !inflight_ff;
   assign busy   = inflight_ff;

   always_comb begin
      in_pool = (32'(req_data.node) < NODES);
      is_mem  = in_pool && member_ff[req_data.node];

      member_in         = member_ff;
      fifo_push         = accept;
      fifo_entry.kind   = KIND_REPORT;
      fifo_entry.node   = req_data.node;
      fifo_entry.found  = 1'b0;
      fifo_entry.status = ST_OK;

      case (req_data.cmd)
         CMD_PUSH: begin
            if (!in_pool || is_mem) begin
               fifo_entry.status = ST_PUSH_REFUSED;
            end else begin
               fifo_entry.kind = KIND_PUSH;
               if (accept) member_in[req_data.node] = 1'b1;
            end
         end
         CMD_POP: begin
            if (!back_stat.nonempty) begin
               fifo_entry.status = ST_POP_EMPTY;
            end else begin
               // Head is stable here: the back is idle whenever a word is taken.
               fifo_entry.kind = KIND_POP;
               fifo_entry.node = back_stat.head;
               if (accept) member_in[back_stat.head] = 1'b0;
            end
         end
         CMD_REMOVE: begin
            if (!is_mem) begin
               fifo_entry.status = ST_REMOVE_MISS;
            end else begin
               fifo_entry.kind = KIND_REMOVE;
               if (accept) member_in[req_data.node] = 1'b0;
            end
         end
         default: begin
            fifo_entry.found = is_mem;
         end
      endcase

      if (accept) begin
         inflight_in = 1'b1;
      end else if (back_stat.done) begin
         inflight_in = 1'b0;
      end else begin
         inflight_in = inflight_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         member_ff   <= '0;
         inflight_ff <= 1'b0;
      end else begin
         member_ff   <= member_in;
         inflight_ff <= inflight_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/dlq_back.sv
// Back: keeps head, tail and the link memories and carries out queued work.
`default_nettype none

module dlq_back
   import dlq_pkg::*;
#(
   parameter int NODES = DLQ_NODES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fifo_valid,
   input  dlq_entry_type      fifo_head,
   output logic               fifo_pop,
   output dlq_back_stat_type  back_stat,
   output logic               rsp_strobe,
   output dlq_rsp_type        rsp_data
);

   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WAIT = 1'b1;

   // Links of the tail (next) and of the head (prev) are never trusted,
   // so a push onto a non-empty list writes one entry in each memory.
   node_type next_mem [NODES];
   node_type prev_mem [NODES];

   logic          state_ff, state_in;
   dlq_entry_type cur_ff, cur_in;
   node_type      head_ff, head_in;
   node_type      tail_ff, tail_in;
   logic          nonempty_ff, nonempty_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   dlq_rsp_type   rsp_data_ff, rsp_data_in;
   node_type      next_rd_ff, prev_rd_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             next_we, prev_we;
   logic [IDX_W-1:0] next_waddr, prev_waddr;
   node_type         next_wdata, prev_wdata;
   logic             has_next, has_prev;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      nonempty_in   = nonempty_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      fifo_pop      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = IDX_W'(head_ff);
      next_we       = 1'b0;
      prev_we       = 1'b0;
      next_waddr    = IDX_W'(tail_ff);
      prev_waddr    = IDX_W'(fifo_head.node);
      next_wdata    = fifo_head.node;
      prev_wdata    = tail_ff;
      has_next      = (cur_ff.node != tail_ff);
      has_prev      = (cur_ff.node != head_ff);

      rsp_data_in.node_out       = '0;
      rsp_data_in.node_out_valid = 1'b0;
      rsp_data_in.found          = 1'b0;
      rsp_data_in.status         = ST_OK;
      rsp_data_in.empty_res      = !nonempty_ff;

      case (state_ff)
         S_IDLE: begin
            if (fifo_valid) begin
               fifo_pop = 1'b1;
               cur_in   = fifo_head;
               case (fifo_head.kind)
                  KIND_PUSH: begin
                     // Link behind the old tail, or start a fresh list.
                     if (nonempty_ff) begin
                        next_we = 1'b1;
                        prev_we = 1'b1;
                     end else begin
                        head_in = fifo_head.node;
                     end
                     tail_in               = fifo_head.node;
                     nonempty_in           = 1'b1;
                     rsp_strobe_in         = 1'b1;
                     rsp_data_in.empty_res = 1'b0;
                  end
                  KIND_POP: begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(head_ff);
                     state_in = S_WAIT;
                  end
                  KIND_REMOVE: begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(fifo_head.node);
                     state_in = S_WAIT;
                  end
                  default: begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.found  = fifo_head.found;
                     rsp_data_in.status = fifo_head.status;
                  end
               endcase
            end
         end
         S_WAIT: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            if (cur_ff.kind == KIND_POP) begin
               rsp_data_in.node_out       = head_ff;
               rsp_data_in.node_out_valid = 1'b1;
               if (head_ff == tail_ff) begin
                  nonempty_in           = 1'b0;
                  head_in               = '0;
                  tail_in               = '0;
                  rsp_data_in.empty_res = 1'b1;
               end else begin
                  head_in = next_rd_ff;
               end
            end else begin
               if (!has_prev && !has_next) begin
                  nonempty_in           = 1'b0;
                  head_in               = '0;
                  tail_in               = '0;
                  rsp_data_in.empty_res = 1'b1;
               end else if (!has_prev) begin
                  head_in = next_rd_ff;
               end else if (!has_next) begin
                  tail_in = prev_rd_ff;
               end else begin
                  // Splice the two neighbors together.
                  next_we    = 1'b1;
                  next_waddr = IDX_W'(prev_rd_ff);
                  next_wdata = next_rd_ff;
                  prev_we    = 1'b1;
                  prev_waddr = IDX_W'(next_rd_ff);
                  prev_wdata = prev_rd_ff;
               end
               if (has_next) begin
                  rsp_data_in.node_out       = next_rd_ff;
                  rsp_data_in.node_out_valid = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign back_stat.done     = rsp_strobe_in;
   assign back_stat.nonempty = nonempty_ff;
   assign back_stat.head     = head_ff;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_data           = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         nonempty_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         nonempty_ff   <= nonempty_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (rd_en) next_rd_ff <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      if (rd_en) prev_rd_ff <= prev_mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/doubly_linked_queue_manager.sv
// Top level of the doubly linked queue manager.
//
// One FIFO of node indices kept as a doubly linked list over a pool of NODES.
// Request channel: drive req_data {cmd, node} and raise start; the word is
// taken at a rising edge where start is high and busy is low. Commands:
// push at tail, pop head, remove any member, test membership.
// Result channel: each word yields one result on rsp_data, shown for exactly
// one cycle with rsp_strobe high. The receiver cannot stall it; take it then.
// rsp_strobe rises once the word has passed the FIFO and the result register
// for push, test and every refused command; pop and remove also read the
// link memories (one registered read port each) and pass the S_WAIT state
// before relinking the neighbors; the result is taken at the edge that ends
// that strobe cycle. busy stays high from acceptance until the result is
// shown, so a new word is taken only once the last word's result is shown.
// The front checks membership flops and guards (pop on empty, push of a
// member or of an index outside the pool, remove of a non-member); a refused
// command changes no state. The back owns head, tail and the link memories.
// Reset (synchronous) empties the list and clears all membership flops at
// once; the link memories need no clearing.
`default_nettype none

module doubly_linked_queue_manager
   import dlq_pkg::*;
#(
   parameter int NODES = DLQ_NODES
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   input  dlq_req_type req_data,
   output logic        rsp_strobe,
   output dlq_rsp_type rsp_data
);

   logic              fifo_push;
   dlq_entry_type     fifo_entry;
   logic              fifo_pop;
   logic              fifo_valid;
   dlq_entry_type     fifo_head;
   dlq_back_stat_type back_stat;

   // Classify each word and update membership as it is taken.
   dlq_front #(
      .NODES(NODES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .back_stat  (back_stat),
      .fifo_push  (fifo_push),
      .fifo_entry (fifo_entry)
   );

   // Hold classified words until the back is free.
   dlq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_entry),
      .pop       (fifo_pop),
      .not_empty (fifo_valid),
      .head_data (fifo_head)
   );

   // Walk the links and register the result word.
   dlq_back #(
      .NODES(NODES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (fifo_valid),
      .fifo_head  (fifo_head),
      .fifo_pop   (fifo_pop),
      .back_stat  (back_stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
